FILE: sv/rrb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the relative range and bearing block.
// No dependencies; used by every module of the block.
package rrb_pkg;

  localparam int XW = 28;  // CORDIC x/y width: 17-bit delta, 8 guard bits, gain headroom
  localparam int ZW = 27;  // angle accumulator, 2^-16 degree units
  localparam int HW = 17;  // body + head heading sum
  localparam int BW = 21;  // bearing before wrap, with room for the correction terms
  localparam int PW = 59;  // magnitude product width

  localparam int TableLen = 24;

  localparam logic [21:0] AtanTab [TableLen] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  localparam logic signed [ZW-1:0] Ang180   = ZW'(11796480);
  localparam logic signed [30:0]   GainQ30  = 31'sd652032874;
  localparam logic signed [PW-1:0] MagRound = PW'(64'sd1 <<< 37);

  localparam logic signed [BW-1:0] FullTurn    = BW'(46080);
  localparam logic signed [BW-1:0] HalfTurn    = BW'(23040);
  localparam logic signed [BW-1:0] UpperLimit2 = BW'(69120);
  localparam logic signed [BW-1:0] LowerLimit1 = -BW'(23040);
  localparam logic signed [BW-1:0] LowerLimit2 = -BW'(69120);

  localparam logic [15:0] DistMax = 16'hFFFF;

  typedef struct packed {
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [HW-1:0] heading;
  } cell_t;

endpackage

FILE: sv/relative_range_and_bearing.sv
`timescale 1ns / 1ps
// Range and relative bearing from observer to target via a CORDIC vectoring chain.
// Depends on rrb_pkg, rrb_cordic_cell and rrb_post.
//
// Accepts one beat per cycle while not stalled and returns one result beat per input beat, in order.
// Each beat passes through one register per CORDIC cell in the chain,
// then the inverse-gain multiplier stage and the output register. The pipeline
// advances as a whole; it holds while a result waits at the output under stall.
// Distance is in 1/256 m and saturates at 65535 with distance_saturated_o set;
// bearing is in 1/128 degree, relative to body plus head heading, in [-180,180).
module relative_range_and_bearing #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] own_x_i,
  input  logic signed [15:0] own_y_i,
  input  logic signed [15:0] body_direction_i,
  input  logic signed [15:0] head_direction_i,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        distance_o,
  output logic signed [15:0] bearing_o,
  output logic               distance_saturated_o
);
  import rrb_pkg::*;

  logic                 en;
  logic signed [16:0]   dx, dy;
  logic signed [XW-1:0] xw, yw;
  cell_t                pre;
  cell_t                chain [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] chain_vld;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  assign dx = 17'(target_x_i) - 17'(own_x_i);
  assign dy = 17'(target_y_i) - 17'(own_y_i);
  assign xw = XW'(dx) <<< 8;
  assign yw = XW'(dy) <<< 8;

  always_comb begin
    pre.zero    = (dx == '0) && (dy == '0);
    pre.heading = 17'(body_direction_i) + 17'(head_direction_i);
    if (dx < 0) begin
      pre.x = -xw;
      pre.y = -yw;
      pre.z = Ang180;
    end else begin
      pre.x = xw;
      pre.y = yw;
      pre.z = '0;
    end
  end

  assign chain[0]     = pre;
  assign chain_vld[0] = in_valid_i;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    rrb_cordic_cell #(.SHIFT(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(chain_vld[g]),
      .cell_i (chain[g]),
      .valid_o(chain_vld[g+1]),
      .cell_o (chain[g+1])
    );
  end

  rrb_post u_post (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .en_i                (en),
    .valid_i             (chain_vld[CORDIC_STAGES]),
    .cell_i              (chain[CORDIC_STAGES]),
    .valid_o             (out_valid_o),
    .distance_o          (distance_o),
    .bearing_o           (bearing_o),
    .distance_saturated_o(distance_saturated_o)
  );

`ifndef NO_ASSERTIONS
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && distance_saturated_o |-> distance_o == DistMax)
    else $error("saturated distance not at maximum");

  a_bearing_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bearing_o >= -16'sd23040) && (bearing_o <= 16'sd23039))
    else $error("bearing outside half-open turn");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");
`endif

endmodule

FILE: sv/rrb_cordic_cell.sv
`timescale 1ns / 1ps
// One CORDIC vectoring micro-rotation with its output register.
// Depends on rrb_pkg for the cell payload type and arctangent table.
module rrb_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  rrb_pkg::cell_t cell_i,
  output logic          valid_o,
  output rrb_pkg::cell_t cell_o
);
  import rrb_pkg::*;

  localparam logic signed [ZW-1:0] Atan = ZW'(AtanTab[SHIFT]);

  logic           valid_q;
  cell_t          cell_d, cell_q;
  logic signed [XW-1:0] xs, ys;

  assign xs = cell_i.x >>> SHIFT;
  assign ys = cell_i.y >>> SHIFT;

  always_comb begin
    cell_d = cell_i;
    if (cell_i.y > 0) begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + Atan;
    end else begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;

endmodule

FILE: sv/rrb_post.sv
`timescale 1ns / 1ps
// Gain correction, saturation and bearing wrap after the CORDIC chain.
// Two register stages; depends on rrb_pkg.
module rrb_post (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  rrb_pkg::cell_t cell_i,
  output logic           valid_o,
  output logic [15:0]    distance_o,
  output logic signed [15:0] bearing_o,
  output logic           distance_saturated_o
);
  import rrb_pkg::*;

  // stage A: multiply by inverse gain, angle rounding and heading subtract
  logic                 valid_a_q;
  logic signed [PW-1:0] prod_d, prod_q;
  logic signed [BW-1:0] b_d, b_q;
  logic signed [ZW-1:0] z_eff;
  logic signed [ZW:0]   z_rnd;
  logic signed [18:0]   ang;

  assign prod_d = cell_i.x * GainQ30;
  assign z_eff  = cell_i.zero ? '0 : cell_i.z;
  assign z_rnd  = (ZW+1)'(z_eff) + (ZW+1)'(256);
  assign ang    = z_rnd[ZW:9];
  assign b_d    = BW'(ang) - BW'(cell_i.heading);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      b_q    <= b_d;
    end
  end

  // stage B: saturate magnitude, wrap bearing into half-open turn
  logic                 valid_b_q;
  logic signed [PW-1:0] sum;
  logic signed [20:0]   mag;
  logic [15:0]          dist_d, dist_q;
  logic                 sat_d, sat_q;
  logic signed [BW-1:0] wrap;
  logic signed [15:0]   bear_q;

  assign sum = prod_q + MagRound;
  assign mag = sum[PW-1:38];

  always_comb begin
    sat_d = 1'b0;
    if (mag < 0) begin
      dist_d = '0;
    end else if (mag > 21'sd65535) begin
      dist_d = DistMax;
      sat_d  = 1'b1;
    end else begin
      dist_d = mag[15:0];
    end
  end

  always_comb begin
    if (b_q >= UpperLimit2) begin
      wrap = b_q - FullTurn - FullTurn;
    end else if (b_q >= HalfTurn) begin
      wrap = b_q - FullTurn;
    end else if (b_q >= LowerLimit1) begin
      wrap = b_q;
    end else if (b_q >= LowerLimit2) begin
      wrap = b_q + FullTurn;
    end else begin
      wrap = b_q + FullTurn + FullTurn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q <= dist_d;
      sat_q  <= sat_d;
      bear_q <= wrap[15:0];
    end
  end

  assign valid_o              = valid_b_q;
  assign distance_o           = dist_q;
  assign bearing_o            = bear_q;
  assign distance_saturated_o = sat_q;

endmodule
